// ===== hw/rtl/ffp_pkg.sv =====
// shared constants, status codes and types for the first-fit table packer
package ffp_pkg;

    localparam int MAX_BINS_DEF = 64;

    localparam int SIZE_W   = 8;
    localparam int VAL_W    = 16;
    localparam int CAP_W    = 8;
    localparam int OCC_W    = 8;
    localparam int TOT_W    = 24;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = 6;
    localparam int INUSE_W  = 7;
    localparam int ENTRY_W  = TOT_W + OCC_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd10;
    localparam logic [TOT_W-1:0] VALUE_MAX = 24'hFF_FFFF;

    localparam logic [STAT_W-1:0] ST_PLACED = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEW    = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic             fits;
        logic [OCC_W-1:0] persons;
        logic [TOT_W-1:0] total;
    } fit_res_t;

endpackage

// ===== hw/rtl/ffp_ram.sv =====
// generic single-write, single-read ram with registered read data
module ffp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ffp_fit_unit.sv =====
// shared fit check and bin update arithmetic for one stored bin
module ffp_fit_unit (
    input  logic [ffp_pkg::CAP_W-1:0]   bin_capacity,
    input  logic [ffp_pkg::SIZE_W-1:0]  group_size,
    input  logic [ffp_pkg::VAL_W-1:0]   group_value,
    input  logic [ffp_pkg::ENTRY_W-1:0] entry,
    output ffp_pkg::fit_res_t           res
);
    import ffp_pkg::*;

    logic [OCC_W-1:0] persons;
    logic [TOT_W-1:0] total;
    logic [CAP_W-1:0] room;
    logic [TOT_W:0]   sum;

    assign persons = entry[OCC_W-1:0];
    assign total   = entry[ENTRY_W-1:OCC_W];
    assign room    = bin_capacity - persons;
    assign sum     = {1'b0, total} + {{(TOT_W + 1 - VAL_W){1'b0}}, group_value};

    always_comb
    begin
        res.fits    = (persons <= bin_capacity) && (room >= group_size);
        res.persons = persons + group_size;
        res.total   = sum[TOT_W] ? VALUE_MAX : sum[TOT_W-1:0];
    end

endmodule

// ===== hw/rtl/first_fit_table_packer_top.sv =====
// top level of the first-fit table packer: scan sequencer, bin store and result register
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, group_size, group_value      | in beat
//  out     | out_valid, out_stall, placement_status,          | out beat
//          | bin_index, bin_occupancy, bin_value_total,       |
//          | bins_in_use                                      |
//  cfg     | cfg_wr_en, cfg_wr_data (bin_capacity)            | write only
//
// a beat scans the open bins in index order, one bin per cycle, to the first that fits;
// with no fit it opens a new bin, or is rejected when all MAX_BINS bins are open
// reset clears the bin count and sets bin_capacity to 10; the store needs no clearing
// in_stall is high from accept until the result is loaded into the output register,
// so the next beat can be accepted in the cycle after that
// a result waiting under out_stall holds the write-back of the next beat
module first_fit_table_packer_top #(
    parameter int MAX_BINS = ffp_pkg::MAX_BINS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ffp_pkg::SIZE_W-1:0]    group_size,
    input  logic [ffp_pkg::VAL_W-1:0]     group_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ffp_pkg::STAT_W-1:0]    placement_status,
    output logic [ffp_pkg::IDX_W-1:0]     bin_index,
    output logic [ffp_pkg::OCC_W-1:0]     bin_occupancy,
    output logic [ffp_pkg::TOT_W-1:0]     bin_value_total,
    output logic [ffp_pkg::INUSE_W-1:0]   bins_in_use,
    input  logic                          cfg_wr_en,
    input  logic [ffp_pkg::CAP_W-1:0]     cfg_wr_data
);
    import ffp_pkg::*;

    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam logic [CNT_W-1:0] BINS_FULL = CNT_W'(MAX_BINS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] open_reg, open_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             found_reg, found_next;
    logic [CAP_W-1:0] cap_reg;
    logic             out_valid_reg, out_valid_next;

    logic [SIZE_W-1:0] size_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [OCC_W-1:0]  upd_occ_reg;
    logic [TOT_W-1:0]  upd_tot_reg;
    logic [STAT_W-1:0] o_status_reg;
    logic [CNT_W-1:0]  o_idx_reg;
    logic [OCC_W-1:0]  o_occ_reg;
    logic [TOT_W-1:0]  o_tot_reg;
    logic [CNT_W-1:0]  o_inuse_reg;

    logic              in_acc;
    logic              slot_free;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    fit_res_t          fit;
    logic              commit;

    ffp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    ffp_fit_unit u_fit (
        .bin_capacity (cap_reg),
        .group_size   (size_reg),
        .group_value  (value_reg),
        .entry        (rd_data),
        .res          (fit)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == S_WRITE) && slot_free;
    assign rd_en     = (state_reg == S_SCAN) && !(cmp_vld_reg && fit.fits)
                       && (rd_idx_reg < open_reg);

    // scan sequencer
    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        found_next   = found_reg;
        open_next    = open_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next   = S_SCAN;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    found_next   = 1'b0;
                end
            end
            S_SCAN:
            begin
                priority if (cmp_vld_reg && fit.fits)
                begin
                    found_next   = 1'b1;
                    cmp_vld_next = 1'b0;
                    state_next   = S_WRITE;
                end
                else if (rd_idx_reg < open_reg)
                begin
                    cmp_idx_next = rd_idx_reg;
                    cmp_vld_next = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                else if (cmp_vld_reg)
                begin
                    cmp_vld_next = 1'b0;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                    if (!found_reg && (open_reg < BINS_FULL))
                    begin
                        open_next = open_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // bin store write-back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmp_idx_reg[ADDR_W-1:0];
        wr_data = {upd_tot_reg, upd_occ_reg};
        if (commit)
        begin
            if (found_reg)
            begin
                wr_en = 1'b1;
            end
            else if (open_reg < BINS_FULL)
            begin
                wr_en   = 1'b1;
                wr_addr = open_reg[ADDR_W-1:0];
                wr_data = {{(TOT_W - VAL_W){1'b0}}, value_reg, size_reg};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            size_reg  <= group_size;
            value_reg <= group_value;
        end
        if ((state_reg == S_SCAN) && cmp_vld_reg && fit.fits)
        begin
            upd_occ_reg <= fit.persons;
            upd_tot_reg <= fit.total;
        end
        if (commit)
        begin
            priority if (found_reg)
            begin
                o_status_reg <= ST_PLACED;
                o_idx_reg    <= cmp_idx_reg;
                o_occ_reg    <= upd_occ_reg;
                o_tot_reg    <= upd_tot_reg;
                o_inuse_reg  <= open_reg;
            end
            else if (open_reg < BINS_FULL)
            begin
                o_status_reg <= ST_NEW;
                o_idx_reg    <= open_reg;
                o_occ_reg    <= size_reg;
                o_tot_reg    <= {{(TOT_W - VAL_W){1'b0}}, value_reg};
                o_inuse_reg  <= open_reg + 1'b1;
            end
            else
            begin
                o_status_reg <= ST_REJECT;
                o_idx_reg    <= '0;
                o_occ_reg    <= '0;
                o_tot_reg    <= '0;
                o_inuse_reg  <= open_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign placement_status = o_status_reg;
    assign bin_index        = IDX_W'(o_idx_reg);
    assign bin_occupancy    = o_occ_reg;
    assign bin_value_total  = o_tot_reg;
    assign bins_in_use      = INUSE_W'(o_inuse_reg);

endmodule
